FILE: src/v3mu_pkg.sv
// Package: types, constants and the payload structs of the vector math unit
package v3mu_pkg;

  localparam int FRAC_BITS_DEF = 12;
  // Component width, fixed for the whole datapath.
  localparam int CW = 24;

  // Widths for the datapath at the default component width.
  localparam int DW = CW + 1;          // difference width (distance)
  localparam int SQW = 2 * DW + 2;     // sum of three squares
  localparam int RW = (SQW + 1) / 2;   // root width
  localparam int QW = CW + 16;         // quotient width, FRAC_BITS up to 16

  typedef enum logic [2:0] {
    MODE_DOT   = 3'd0,
    MODE_CROSS = 3'd1,
    MODE_SQMAG = 3'd2,
    MODE_MAG   = 3'd3,
    MODE_NORM  = 3'd4,
    MODE_DIST  = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] res_x;
    logic signed [CW-1:0] res_y;
    logic signed [CW-1:0] res_z;
    logic signed [CW-1:0] scalar;
    logic                 zero_length;
    logic                 saturated;
  } out_item_t;

  // Item context carried down the cell chain.
  typedef struct packed {
    logic [2:0]            mode;
    logic signed [DW-1:0]  vx;
    logic signed [DW-1:0]  vy;
    logic signed [DW-1:0]  vz;
    logic signed [SQW-1:0] sum;
    logic signed [SQW+1:0] dot;
    logic signed [SQW-1:0] cx;
    logic signed [SQW-1:0] cy;
    logic signed [SQW-1:0] cz;
  } ctx_t;

endpackage

FILE: src/v3mu_sqrt_cell.sv
// Module: one restoring square-root cell, one root bit per stage
module v3mu_sqrt_cell #(
  parameter int W = 50,
  parameter int RWID = 25,
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  logic [W-1:0]    rem_in,
  input  logic [RWID-1:0] root_in,
  output logic            vld_r,
  output logic [W-1:0]    rem_r,
  output logic [RWID-1:0] root_r
);
  logic [W+1:0] trial;
  logic [W+1:0] rem_ext;

  always_comb begin
    trial   = (({{(W+2-RWID){1'b0}}, root_in}) << (BIT + 1))
            + ((W+2)'(1) << (2 * BIT));
    rem_ext = {2'b00, rem_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_ext >= trial) begin
        rem_r  <= W'(rem_ext - trial);
        root_r <= root_in | (RWID'(1) << BIT);
      end else begin
        rem_r  <= rem_in;
        root_r <= root_in;
      end
    end
  end
endmodule

FILE: src/v3mu_div_cell.sv
// Module: one restoring divider cell for all three components, one quotient bit per stage
module v3mu_div_cell #(
  parameter int QWID = 40,
  parameter int RWID = 25,
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RWID-1:0]   den,
  input  logic [3*QWID-1:0] num_in,
  input  logic [3*RWID-1:0] rem_in,
  output logic [3*QWID-1:0] num_r,
  output logic [3*RWID-1:0] rem_r
);
  logic [3*QWID-1:0] num_nxt;
  logic [3*RWID-1:0] rem_nxt;
  logic [RWID:0]     part;

  always_comb begin
    num_nxt = num_in;
    rem_nxt = rem_in;
    part    = '0;
    for (int k = 0; k < 3; k++) begin
      part = {rem_in[k*RWID +: RWID], num_in[k*QWID + BIT]};
      if (part >= {1'b0, den}) begin
        part = part - {1'b0, den};
        num_nxt[k*QWID + BIT] = 1'b1;
      end else begin
        num_nxt[k*QWID + BIT] = 1'b0;
      end
      rem_nxt[k*RWID +: RWID] = part[RWID-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule

FILE: src/vector3_math_unit_top.sv
// Module: top level of the vector math unit, a chain of pipeline cells
// Fully pipelined: one item per clock while results are taken. The pipeline holds an input register, a product
// register and a sum register, one cell per root bit in the square-root chain (RW = 26
// cells), one cell per quotient bit in the divider chain (CW+FRAC_BITS = 36 cells at the
// defaults) and an output register. The chain stalls as a whole when the result is not
// taken; the input is ready whenever the output register is free or being drained.
module vector3_math_unit_top #(
  parameter int FRAC_BITS = v3mu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  v3mu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output v3mu_pkg::out_item_t out_data
);
  import v3mu_pkg::*;

  localparam int NQ = CW + FRAC_BITS;
  localparam int NS = RW;
  localparam logic signed [SQW+1:0] MAXV = (SQW+2)'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [SQW+1:0] MINV = -MAXV - 1;

  logic en;

  // stage 0: input register
  logic  s0_v_r;
  logic [2:0] s0_mode_r;
  logic signed [CW-1:0] s0_ax_r, s0_ay_r, s0_az_r, s0_bx_r, s0_by_r, s0_bz_r;

  // stage 1: products
  logic s1_v_r;
  logic [2:0] s1_mode_r;
  logic signed [DW-1:0] s1_vx_r, s1_vy_r, s1_vz_r;
  logic signed [2*DW-1:0] s1_p_r [9];

  // stage 2: sums
  logic s2_v_r;
  ctx_t s2_r;

  // sqrt chain
  logic              sq_v   [NS+1];
  logic [SQW-1:0]    sq_rem [NS+1];
  logic [RW-1:0]     sq_root[NS+1];
  ctx_t              sq_ctx [NS+1];

  // divide chain
  logic [3*QW-1:0]   dv_num [NQ+1];
  logic [3*RW-1:0]   dv_rem [NQ+1];
  logic              dv_v   [NQ+1];
  ctx_t              dv_ctx [NQ+1];
  logic [RW-1:0]     dv_den [NQ+1];

  out_item_t out_nxt;
  logic      out_v_r;
  out_item_t out_r;

  assign en        = !out_v_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode_r <= in_data.mode;
      s0_ax_r <= in_data.a_x; s0_ay_r <= in_data.a_y; s0_az_r <= in_data.a_z;
      s0_bx_r <= in_data.b_x; s0_by_r <= in_data.b_y; s0_bz_r <= in_data.b_z;
    end
  end

  logic signed [DW-1:0] vx, vy, vz, ax, ay, az, bx, by, bz;
  always_comb begin
    ax = DW'(s0_ax_r); ay = DW'(s0_ay_r); az = DW'(s0_az_r);
    bx = DW'(s0_bx_r); by = DW'(s0_by_r); bz = DW'(s0_bz_r);
    if (s0_mode_r == MODE_DIST) begin
      vx = ax - bx; vy = ay - by; vz = az - bz;
    end else begin
      vx = ax; vy = ay; vz = az;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= s0_mode_r;
      s1_vx_r <= vx; s1_vy_r <= vy; s1_vz_r <= vz;
      if (s0_mode_r == MODE_DOT) begin
        s1_p_r[0] <= ax * bx; s1_p_r[1] <= ay * by; s1_p_r[2] <= az * bz;
      end else begin
        s1_p_r[0] <= vx * vx; s1_p_r[1] <= vy * vy; s1_p_r[2] <= vz * vz;
      end
      s1_p_r[3] <= ay * bz; s1_p_r[4] <= by * az;
      s1_p_r[5] <= az * bx; s1_p_r[6] <= bz * ax;
      s1_p_r[7] <= ax * by; s1_p_r[8] <= bx * ay;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.mode <= s1_mode_r;
      s2_r.vx <= s1_vx_r; s2_r.vy <= s1_vy_r; s2_r.vz <= s1_vz_r;
      s2_r.dot <= (SQW+2)'(s1_p_r[0]) + (SQW+2)'(s1_p_r[1]) + (SQW+2)'(s1_p_r[2]);
      s2_r.sum <= SQW'((SQW+2)'(s1_p_r[0]) + (SQW+2)'(s1_p_r[1]) + (SQW+2)'(s1_p_r[2]));
      s2_r.cx <= SQW'(s1_p_r[3]) - SQW'(s1_p_r[4]);
      s2_r.cy <= SQW'(s1_p_r[5]) - SQW'(s1_p_r[6]);
      s2_r.cz <= SQW'(s1_p_r[7]) - SQW'(s1_p_r[8]);
    end
  end

  assign sq_v[0]    = s2_v_r;
  assign sq_rem[0]  = s2_r.sum;
  assign sq_root[0] = '0;
  assign sq_ctx[0]  = s2_r;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    v3mu_sqrt_cell #(.W(SQW), .RWID(RW), .BIT(NS - 1 - i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(sq_v[i]), .rem_in(sq_rem[i]), .root_in(sq_root[i]),
      .vld_r(sq_v[i+1]), .rem_r(sq_rem[i+1]), .root_r(sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctx[i+1] <= sq_ctx[i];
      end
    end
  end

  function automatic logic [QW-1:0] mag_num(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return QW'(m);
  endfunction

  assign dv_v[0]   = sq_v[NS];
  assign dv_ctx[0] = sq_ctx[NS];
  assign dv_den[0] = sq_root[NS];
  assign dv_rem[0] = '0;
  assign dv_num[0] = {mag_num(sq_ctx[NS].vz) << FRAC_BITS,
                      mag_num(sq_ctx[NS].vy) << FRAC_BITS,
                      mag_num(sq_ctx[NS].vx) << FRAC_BITS};

  for (genvar j = 0; j < NQ; j++) begin : g_div
    v3mu_div_cell #(.QWID(QW), .RWID(RW), .BIT(NQ - 1 - j)) u_cell (
      .clk(clk), .en(en), .den(dv_den[j]),
      .num_in(dv_num[j]), .rem_in(dv_rem[j]),
      .num_r(dv_num[j+1]), .rem_r(dv_rem[j+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctx[j+1] <= dv_ctx[j];
        dv_den[j+1] <= dv_den[j];
      end
    end
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [SQW+1:0] v,
                                                inout logic flag);
    if (v < MINV) begin
      flag = 1'b1;
      return CW'(MINV);
    end else if (v > MAXV) begin
      flag = 1'b1;
      return CW'(MAXV);
    end
    return CW'(v);
  endfunction

  ctx_t          fc;
  logic [RW-1:0] root;
  logic          sflag;
  logic signed [SQW+1:0] q [3];
  always_comb begin
    fc = dv_ctx[NQ];
    root = dv_den[NQ];
    sflag = 1'b0;
    out_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      q[k] = (SQW+2)'(dv_num[NQ][k*QW +: QW]);
    end
    if (fc.vx[DW-1]) q[0] = -q[0];
    if (fc.vy[DW-1]) q[1] = -q[1];
    if (fc.vz[DW-1]) q[2] = -q[2];
    unique case (fc.mode)
      MODE_DOT:   out_nxt.scalar = sat(fc.dot >>> FRAC_BITS, sflag);
      MODE_CROSS: begin
        out_nxt.res_x = sat((SQW+2)'(fc.cx) >>> FRAC_BITS, sflag);
        out_nxt.res_y = sat((SQW+2)'(fc.cy) >>> FRAC_BITS, sflag);
        out_nxt.res_z = sat((SQW+2)'(fc.cz) >>> FRAC_BITS, sflag);
      end
      MODE_SQMAG: out_nxt.scalar = sat(fc.dot >>> FRAC_BITS, sflag);
      MODE_MAG, MODE_DIST: out_nxt.scalar = sat((SQW+2)'(root), sflag);
      MODE_NORM: begin
        if (root == '0) begin
          out_nxt.zero_length = 1'b1;
        end else begin
          out_nxt.res_x = sat(q[0], sflag);
          out_nxt.res_y = sat(q[1], sflag);
          out_nxt.res_z = sat(q[2], sflag);
        end
      end
      default: out_nxt = '0;
    endcase
    out_nxt.saturated = sflag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end
endmodule

FILE: src/v3mu_checker.sv
// Module: port checker for the vector math unit, bound to the top level
module v3mu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input v3mu_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_zl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.res_x == 0 && out_data.res_y == 0 && out_data.res_z == 0 &&
      out_data.scalar == 0 && !out_data.saturated)
    else $error("zero-length result not clean");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");
endmodule

bind vector3_math_unit_top v3mu_checker u_v3mu_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
